FILE: rtl/grs_pkg.sv
// Package for the group reverse stream block: word types for both channels,
// the shift control struct shared by the cell chain, and field widths.
// No dependencies.
`timescale 1ns / 1ps

package grs_pkg;

  localparam int unsigned VALUE_W      = 64;
  localparam int unsigned GROUP_SIZE_W = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_final;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      run_last;
    logic                      list_end;
  } out_word_t;

  // Push moves every cell one place away from the head and loads the new
  // value into the head. Pop moves every cell one place toward the head.
  typedef struct packed {
    logic push;
    logic pop;
  } grs_shift_t;

endpackage

FILE: rtl/grs_cell.sv
// One storage cell of the group chain: holds a single element and loads it
// from either neighbor under the shared shift control.
// Depends on grs_pkg.
`timescale 1ns / 1ps

module grs_cell
  import grs_pkg::*;
(
  input  logic                      clk_i,
  input  grs_shift_t                shift_i,
  input  logic signed [VALUE_W-1:0] near_i,
  input  logic signed [VALUE_W-1:0] far_i,
  output logic signed [VALUE_W-1:0] value_o
);

  logic signed [VALUE_W-1:0] value_q;
  logic signed [VALUE_W-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (shift_i.push) begin
      value_d = near_i;
    end else if (shift_i.pop) begin
      value_d = far_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/grs_chain.sv
// Row of grs_cell instances that holds the group being collected, newest
// element at the head, plus a read port for emitting in arrival order.
// Depends on grs_pkg and grs_cell.
`timescale 1ns / 1ps

module grs_chain
  import grs_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  grs_shift_t                shift_i,
  input  logic signed [VALUE_W-1:0] push_value_i,
  input  logic        [IDX_W-1:0]   rd_idx_i,
  output logic signed [VALUE_W-1:0] head_value_o,
  output logic signed [VALUE_W-1:0] rd_value_o
);

  logic signed [VALUE_W-1:0] cell_value [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] near_value;
    logic signed [VALUE_W-1:0] far_value;

    if (i == 0) begin : g_head
      assign near_value = push_value_i;
    end else begin : g_body
      assign near_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign far_value = '0;
    end else begin : g_inner
      assign far_value = cell_value[i+1];
    end

    grs_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .near_i  (near_value),
      .far_i   (far_value),
      .value_o (cell_value[i])
    );
  end

  assign head_value_o = cell_value[0];
  assign rd_value_o   = cell_value[rd_idx_i];

endmodule

FILE: rtl/group_reverse_stream_core.sv
// Group reverse stream: collects input words into groups of group_size and
// emits each full group newest first; a trailing partial group leaves in
// arrival order. The input channel carries one element and a final mark per
// word; the output channel carries one reordered element per word, with
// run_last on the last word caused by an input word and list_end on the last
// word of the whole list. group_size is written through cfg_we_i/cfg_data_i;
// the user writes it only while the block is idle (not enforced by the block).
// 0 or 1 passes words through, values above MAX_GROUP act as MAX_GROUP.
// While a group is being collected one input word is taken every cycle. The
// word that completes a group (or carries the final mark) starts emission:
// the n held elements leave one per cycle from the cell chain while the
// output is not stalled, the first entering the output register once the
// state register has left collection; input is stalled until the last of
// them has left, so no new word is taken during emission, in pass-through
// too. Stalling the output holds the output register and pauses emission.
// Reset empties the group and clears group_size to 0; cell contents stay.
// Depends on grs_pkg and grs_chain.
`timescale 1ns / 1ps

module group_reverse_stream_core
  import grs_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_word_o,
  input  logic                    cfg_we_i,
  input  logic [GROUP_SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
  localparam int unsigned IDX_W = $clog2(MAX_GROUP);
  localparam int unsigned CMP_W = 8;

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_REV     = 2'd1;
  localparam logic [1:0] ST_FWD     = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    final_q, final_d;
  logic [GROUP_SIZE_W-1:0] size_q, size_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic                      in_accept;
  logic                      out_free;
  logic                      emit;
  logic                      emit_last;
  grs_shift_t                shift;
  logic signed [VALUE_W-1:0] head_value;
  logic signed [VALUE_W-1:0] rd_value;
  logic        [IDX_W-1:0]   rd_idx;
  logic        [CMP_W-1:0]   size_w;
  logic        [CMP_W-1:0]   eff_size;
  logic        [CMP_W-1:0]   fill_next;
  logic        [CNT_W-1:0]   cnt_inc;

  assign in_stall_o = (state_q != ST_COLLECT);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q != ST_COLLECT) && out_free;
  assign emit_last  = (cnt_q == CNT_W'(1));

  // Sizes 0 and 1 both mean a group of one.
  assign size_w = CMP_W'(size_q);
  always_comb begin
    if (size_w < CMP_W'(2)) begin
      eff_size = CMP_W'(1);
    end else if (size_w > CMP_W'(MAX_GROUP)) begin
      eff_size = CMP_W'(MAX_GROUP);
    end else begin
      eff_size = size_w;
    end
  end

  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign fill_next = CMP_W'(cnt_inc);

  assign shift.push = in_accept;
  assign shift.pop  = emit && (state_q == ST_REV);
  assign rd_idx     = IDX_W'(cnt_q - CNT_W'(1));

  grs_chain #(
    .DEPTH (MAX_GROUP),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk_i        (clk_i),
    .shift_i      (shift),
    .push_value_i (in_word_i.value),
    .rd_idx_i     (rd_idx),
    .head_value_o (head_value),
    .rd_value_o   (rd_value)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    final_d     = final_q;
    size_d      = size_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (cfg_we_i) begin
      size_d = cfg_data_i;
    end

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_accept) begin
      cnt_d   = cnt_inc;
      final_d = in_word_i.is_final;
      if (fill_next >= eff_size) begin
        state_d = ST_REV;
      end else if (in_word_i.is_final) begin
        state_d = ST_FWD;
      end
    end

    if (emit) begin
      out_valid_d          = 1'b1;
      out_word_d.run_last  = emit_last;
      cnt_d                = cnt_q - CNT_W'(1);
      case (state_q)
        ST_REV: begin
          out_word_d.out_value = head_value;
          out_word_d.list_end  = emit_last && final_q;
        end
        default: begin
          out_word_d.out_value = rd_value;
          out_word_d.list_end  = emit_last;
        end
      endcase
      if (emit_last) begin
        state_d = ST_COLLECT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      cnt_q       <= '0;
      final_q     <= 1'b0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      final_q     <= final_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // A word is loaded into the output register only during emission.
  a_no_load_in_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLLECT) |=> !$rose(out_valid_q))
    else $error("output loaded while collecting");

  // The group never holds more than the chain can store.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_GROUP))
    else $error("fill count beyond chain depth");

  // Emission always has at least one element left to send.
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_COLLECT) |-> (cnt_q != '0))
    else $error("emitting from an empty group");

  // Each emitted word removes exactly one element from the group.
  a_emit_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("fill count not decremented on emit");

  // The end of the list is always the end of a run.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.list_end) |-> out_word_o.run_last)
    else $error("list_end without run_last");
`endif

endmodule
